/* sv/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Types and codes shared by the complex arithmetic unit and its parts.
// ----------------------------------------------------------------------------
package cau_pkg;

    // operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_MAG = 3'd5
    } op_t;

    // number of quotient / root bits produced by the iterative stages
    localparam int ITER_STAGES = 32;

    // request payload
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } req_t;

    // response payload
    typedef struct packed {
        logic signed [31:0] result_real;
        logic signed [31:0] result_imag;
        logic               are_equal;
        logic               overflowed;
        logic               divide_by_zero;
    } rsp_t;

    // state carried through the divide / square root stages
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] base_re;
        logic [31:0] base_im;
        logic        eq;
        logic        ovf;
        logic        dz;
        logic [63:0] d;
        logic [64:0] drem_re;
        logic [64:0] drem_im;
        logic [31:0] q_re;
        logic [31:0] q_im;
        logic [31:0] lo_re;
        logic [31:0] lo_im;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [35:0] srem;
        logic [31:0] root;
        logic [63:0] sbits;
    } step_t;

endpackage

/* sv/cau_chan_if.sv */
// ----------------------------------------------------------------------------
// cau_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface cau_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/cau_step.sv */
// ----------------------------------------------------------------------------
// cau_step
// One pipeline stage of the iterative part: one restoring divide step for
// each of the two quotients and one digit step of the integer square root.
// ----------------------------------------------------------------------------
module cau_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            src_valid,
    input  cau_pkg::step_t  src,
    output logic            dst_valid,
    output cau_pkg::step_t  dst
);
    import cau_pkg::*;

    logic  valid_reg;
    step_t stage_reg;
    step_t stage_next;

    logic [64:0] dr_re;
    logic [64:0] dr_im;
    logic [64:0] dd;
    logic [35:0] sr;
    logic [35:0] trial;

    // one quotient bit per divider, one root bit
    always_comb
    begin
        stage_next = src;
        dd         = {1'b0, src.d};

        dr_re = {src.drem_re[63:0], src.lo_re[31]};
        if (dr_re >= dd)
        begin
            stage_next.drem_re = dr_re - dd;
            stage_next.q_re    = {src.q_re[30:0], 1'b1};
        end
        else
        begin
            stage_next.drem_re = dr_re;
            stage_next.q_re    = {src.q_re[30:0], 1'b0};
        end

        dr_im = {src.drem_im[63:0], src.lo_im[31]};
        if (dr_im >= dd)
        begin
            stage_next.drem_im = dr_im - dd;
            stage_next.q_im    = {src.q_im[30:0], 1'b1};
        end
        else
        begin
            stage_next.drem_im = dr_im;
            stage_next.q_im    = {src.q_im[30:0], 1'b0};
        end

        stage_next.lo_re = {src.lo_re[30:0], 1'b0};
        stage_next.lo_im = {src.lo_im[30:0], 1'b0};

        sr    = {src.srem[33:0], src.sbits[63:62]};
        trial = {2'b00, src.root, 2'b01};
        if (sr >= trial)
        begin
            stage_next.srem = sr - trial;
            stage_next.root = {src.root[30:0], 1'b1};
        end
        else
        begin
            stage_next.srem = sr;
            stage_next.root = {src.root[30:0], 1'b0};
        end
        stage_next.sbits = {src.sbits[61:0], 2'b00};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= src_valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst       = stage_reg;

endmodule

/* sv/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply, divide, compare and magnitude
// on signed fixed point operands, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  req     | sink   | operation, a_re, a_im, b_re, b_im
//  rsp     | source | result_real, result_imag, are_equal, overflowed,
//          |        | divide_by_zero
//
// One request enters per cycle while the pipeline is not stalled; each response
// passes through five front stages, 32 divide / square root digit stages (one
// quotient and one root bit per stage) and the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is dropped or repeated.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    cau_chan_if.sink   req,
    cau_chan_if.source rsp
);
    import cau_pkg::*;

    localparam int HI_SHIFT = 32 - FRAC_BITS;
    localparam logic [31:0] MAXPOS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAXNEG = 32'h8000_0000;

    logic en;

    // saturate a 33-bit signed sum
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        begin
            if (v[32] != v[31])
            begin
                r = v[32] ? {1'b1, MAXNEG} : {1'b1, MAXPOS};
            end
            else
            begin
                r = {1'b0, v[31:0]};
            end
            return r;
        end
    endfunction

    // saturate a 65-bit signed value
    function automatic logic [32:0] sat65(input logic signed [64:0] v);
        logic [32:0] r;
        begin
            if (v[64:31] != {34{v[64]}})
            begin
                r = v[64] ? {1'b1, MAXNEG} : {1'b1, MAXPOS};
            end
            else
            begin
                r = {1'b0, v[31:0]};
            end
            return r;
        end
    endfunction

    // saturate a sign/magnitude quotient
    function automatic logic [32:0] sat_q(input logic big, input logic neg,
                                          input logic [31:0] q);
        logic [32:0] r;
        begin
            if (big)
            begin
                r = neg ? {1'b1, MAXNEG} : {1'b1, MAXPOS};
            end
            else if (!neg)
            begin
                r = (q > MAXPOS) ? {1'b1, MAXPOS} : {1'b0, q};
            end
            else
            begin
                r = (q > MAXNEG) ? {1'b1, MAXNEG} : {1'b0, 32'(-q)};
            end
            return r;
        end
    endfunction

    // ------------------------------------------------------------------
    // stage A: operands, add / subtract / compare
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic [2:0]         a_op_reg;
    logic signed [31:0] a_are_reg, a_aim_reg, a_bre_reg, a_bim_reg;
    logic [31:0]        a_base_re_reg, a_base_im_reg;
    logic               a_eq_reg, a_ovf_reg;

    logic [31:0]        a_base_re_next, a_base_im_next;
    logic               a_eq_next, a_ovf_next;
    logic signed [32:0] s_re, s_im;
    logic [32:0]        t_re, t_im;

    always_comb
    begin
        a_base_re_next = '0;
        a_base_im_next = '0;
        a_eq_next      = 1'b0;
        a_ovf_next     = 1'b0;
        if (req.payload.operation == OP_SUB)
        begin
            s_re = 33'(req.payload.a_re) - 33'(req.payload.b_re);
            s_im = 33'(req.payload.a_im) - 33'(req.payload.b_im);
        end
        else
        begin
            s_re = 33'(req.payload.a_re) + 33'(req.payload.b_re);
            s_im = 33'(req.payload.a_im) + 33'(req.payload.b_im);
        end
        t_re = sat33(s_re);
        t_im = sat33(s_im);
        case (req.payload.operation)
            OP_ADD, OP_SUB:
            begin
                a_base_re_next = t_re[31:0];
                a_base_im_next = t_im[31:0];
                a_ovf_next     = t_re[32] | t_im[32];
            end
            OP_CMP:
            begin
                a_eq_next = (req.payload.a_re == req.payload.b_re) &&
                            (req.payload.a_im == req.payload.b_im);
            end
            default:
            begin
                a_eq_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // stage B: products
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic [2:0]         b_op_reg;
    logic [31:0]        b_base_re_reg, b_base_im_reg;
    logic               b_eq_reg, b_ovf_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [31:0] x4, x5;

    assign x4 = (a_op_reg == OP_MAG) ? a_are_reg : a_bre_reg;
    assign x5 = (a_op_reg == OP_MAG) ? a_aim_reg : a_bim_reg;

    // ------------------------------------------------------------------
    // stage C: cross-product sums and divisor / sum of squares
    // ------------------------------------------------------------------
    logic               c_valid_reg;
    logic [2:0]         c_op_reg;
    logic [31:0]        c_base_re_reg, c_base_im_reg;
    logic               c_eq_reg, c_ovf_reg;
    logic signed [64:0] c_num_re_reg, c_num_im_reg;
    logic [63:0]        c_d_reg;
    logic signed [64:0] c_num_re_next, c_num_im_next;

    always_comb
    begin
        if (b_op_reg == OP_DIV)
        begin
            c_num_re_next = 65'(p0_reg) + 65'(p1_reg);
            c_num_im_next = 65'(p3_reg) - 65'(p2_reg);
        end
        else
        begin
            c_num_re_next = 65'(p0_reg) - 65'(p1_reg);
            c_num_im_next = 65'(p2_reg) + 65'(p3_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage D: multiply rounding, sign / magnitude of the numerators
    // ------------------------------------------------------------------
    logic               d_valid_reg;
    logic [2:0]         d_op_reg;
    logic [31:0]        d_base_re_reg, d_base_im_reg;
    logic               d_eq_reg, d_ovf_reg, d_dz_reg;
    logic [63:0]        d_d_reg, d_mag_re_reg, d_mag_im_reg;
    logic               d_neg_re_reg, d_neg_im_reg;

    logic [31:0]        d_base_re_next, d_base_im_next;
    logic               d_ovf_next;
    logic signed [64:0] fl_re, fl_im, ng_re, ng_im;
    logic [32:0]        m_re, m_im;

    always_comb
    begin
        fl_re = c_num_re_reg >>> FRAC_BITS;
        fl_im = c_num_im_reg >>> FRAC_BITS;
        m_re  = sat65(fl_re);
        m_im  = sat65(fl_im);
        ng_re = -c_num_re_reg;
        ng_im = -c_num_im_reg;
        d_base_re_next = c_base_re_reg;
        d_base_im_next = c_base_im_reg;
        d_ovf_next     = c_ovf_reg;
        if (c_op_reg == OP_MUL)
        begin
            d_base_re_next = m_re[31:0];
            d_base_im_next = m_im[31:0];
            d_ovf_next     = m_re[32] | m_im[32];
        end
    end

    // ------------------------------------------------------------------
    // stage E: divider / square root setup
    // ------------------------------------------------------------------
    logic  e_valid_reg;
    step_t e_reg;
    step_t e_next;
    logic [63:0] hi_re, hi_im;

    always_comb
    begin
        hi_re = d_mag_re_reg >> HI_SHIFT;
        hi_im = d_mag_im_reg >> HI_SHIFT;
        e_next.op      = d_op_reg;
        e_next.base_re = d_base_re_reg;
        e_next.base_im = d_base_im_reg;
        e_next.eq      = d_eq_reg;
        e_next.ovf     = d_ovf_reg;
        e_next.dz      = d_dz_reg;
        e_next.d       = d_d_reg;
        e_next.drem_re = {1'b0, hi_re};
        e_next.drem_im = {1'b0, hi_im};
        e_next.q_re    = '0;
        e_next.q_im    = '0;
        e_next.lo_re   = d_mag_re_reg[31:0] << FRAC_BITS;
        e_next.lo_im   = d_mag_im_reg[31:0] << FRAC_BITS;
        e_next.neg_re  = d_neg_re_reg;
        e_next.neg_im  = d_neg_im_reg;
        e_next.big_re  = hi_re >= d_d_reg;
        e_next.big_im  = hi_im >= d_d_reg;
        e_next.srem    = '0;
        e_next.root    = '0;
        e_next.sbits   = d_d_reg;
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= req.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // front stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg      <= req.payload.operation;
            a_are_reg     <= req.payload.a_re;
            a_aim_reg     <= req.payload.a_im;
            a_bre_reg     <= req.payload.b_re;
            a_bim_reg     <= req.payload.b_im;
            a_base_re_reg <= a_base_re_next;
            a_base_im_reg <= a_base_im_next;
            a_eq_reg      <= a_eq_next;
            a_ovf_reg     <= a_ovf_next;

            b_op_reg      <= a_op_reg;
            b_base_re_reg <= a_base_re_reg;
            b_base_im_reg <= a_base_im_reg;
            b_eq_reg      <= a_eq_reg;
            b_ovf_reg     <= a_ovf_reg;
            p0_reg        <= a_are_reg * a_bre_reg;
            p1_reg        <= a_aim_reg * a_bim_reg;
            p2_reg        <= a_are_reg * a_bim_reg;
            p3_reg        <= a_aim_reg * a_bre_reg;
            p4_reg        <= x4 * x4;
            p5_reg        <= x5 * x5;

            c_op_reg      <= b_op_reg;
            c_base_re_reg <= b_base_re_reg;
            c_base_im_reg <= b_base_im_reg;
            c_eq_reg      <= b_eq_reg;
            c_ovf_reg     <= b_ovf_reg;
            c_num_re_reg  <= c_num_re_next;
            c_num_im_reg  <= c_num_im_next;
            c_d_reg       <= 64'(p4_reg) + 64'(p5_reg);

            d_op_reg      <= c_op_reg;
            d_base_re_reg <= d_base_re_next;
            d_base_im_reg <= d_base_im_next;
            d_eq_reg      <= c_eq_reg;
            d_ovf_reg     <= d_ovf_next;
            d_dz_reg      <= (c_op_reg == OP_DIV) && (c_d_reg == '0);
            d_d_reg       <= c_d_reg;
            d_neg_re_reg  <= c_num_re_reg[64];
            d_neg_im_reg  <= c_num_im_reg[64];
            d_mag_re_reg  <= c_num_re_reg[64] ? ng_re[63:0] : c_num_re_reg[63:0];
            d_mag_im_reg  <= c_num_im_reg[64] ? ng_im[63:0] : c_num_im_reg[63:0];

            e_reg         <= e_next;
        end
    end

    // ------------------------------------------------------------------
    // digit stages
    // ------------------------------------------------------------------
    logic  it_valid [ITER_STAGES+1];
    step_t it_data  [ITER_STAGES+1];

    assign it_valid[0] = e_valid_reg;
    assign it_data[0]  = e_reg;

    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_step
        cau_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (it_valid[k]),
            .src       (it_data[k]),
            .dst_valid (it_valid[k+1]),
            .dst       (it_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: quotient and root saturation, result select
    // ------------------------------------------------------------------
    logic  out_valid_reg;
    rsp_t  out_reg;
    rsp_t  out_next;
    step_t fin;
    logic [32:0] f_re, f_im;

    assign fin = it_data[ITER_STAGES];

    always_comb
    begin
        f_re = sat_q(fin.big_re, fin.neg_re, fin.q_re);
        f_im = sat_q(fin.big_im, fin.neg_im, fin.q_im);
        out_next.result_real    = fin.base_re;
        out_next.result_imag    = fin.base_im;
        out_next.are_equal      = fin.eq;
        out_next.overflowed     = fin.ovf;
        out_next.divide_by_zero = 1'b0;
        case (fin.op)
            OP_DIV:
            begin
                if (fin.dz)
                begin
                    out_next.result_real    = '0;
                    out_next.result_imag    = '0;
                    out_next.overflowed     = 1'b0;
                    out_next.divide_by_zero = 1'b1;
                end
                else
                begin
                    out_next.result_real = f_re[31:0];
                    out_next.result_imag = f_im[31:0];
                    out_next.overflowed  = f_re[32] | f_im[32];
                end
            end
            OP_MAG:
            begin
                out_next.result_real = (fin.root > MAXPOS) ? MAXPOS : fin.root;
                out_next.result_imag = '0;
                out_next.overflowed  = fin.root > MAXPOS;
            end
            default:
            begin
                out_next.divide_by_zero = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= it_valid[ITER_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    // pipeline advance
    assign en          = !out_valid_reg || rsp.ready;
    assign req.ready   = en;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule
